// ----- rtl/lssp_pkg.sv -----
// lssp_pkg: shared widths, register codes, reset values and sensor pattern tables
// for the line sensor steering pd unit; no dependencies
package lssp_pkg;

	// field widths
	localparam int SENSOR_W   = 8;
	localparam int ERR_W      = 6;
	localparam int STEER_W    = 22;
	localparam int SPEED_W    = 16;
	localparam int GAIN_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SELECT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CURVE_COEF   = 3'd4;

	// table select codes
	localparam logic TABLE_EIGHT = 1'b0;
	localparam logic TABLE_SEVEN = 1'b1;

	// register reset values
	localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = -16'sd448;
	localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = -16'sd166;
	localparam logic [SPEED_W-1:0]       BASE_SPEED_RST = 16'd7680;
	localparam logic [GAIN_W-1:0]        CURVE_COEF_RST = 16'd2365;

	// largest error magnitude, given for the all-ones pattern
	localparam logic signed [ERR_W-1:0] ERR_FULL_POS = 6'sd16;
	localparam logic signed [ERR_W-1:0] ERR_FULL_NEG = -6'sd16;

	typedef logic signed [ERR_W-1:0] err_t;

	// eight-sensor pattern table, last_pos tells whether the previous error was positive
	function automatic err_t map_eight(input logic [SENSOR_W-1:0] b, input logic last_pos);
		err_t e;
		unique case (b)
			8'hE7, 8'hC3:        e = 6'sd0;
			8'h00, 8'h0F, 8'h07: e = -6'sd9;
			8'hF0, 8'hE0:        e = 6'sd9;
			8'hE3, 8'hF7:        e = 6'sd2;
			8'hC1:               e = 6'sd1;
			8'hF3:               e = 6'sd4;
			8'hF1, 8'hFB:        e = 6'sd6;
			8'hF9, 8'hFD:        e = 6'sd8;
			8'hF8:               e = 6'sd10;
			8'hFC:               e = 6'sd12;
			8'hFE:               e = 6'sd14;
			8'h87:               e = -6'sd2;
			8'hC7:               e = -6'sd1;
			8'hEF:               e = -6'sd2;
			8'hCF:               e = -6'sd4;
			8'h8F, 8'hDF:        e = -6'sd6;
			8'h9F, 8'hBF:        e = -6'sd8;
			8'h1F:               e = -6'sd10;
			8'h3F:               e = -6'sd12;
			8'h7F:               e = -6'sd14;
			8'hFF:               e = last_pos ? ERR_FULL_POS : ERR_FULL_NEG;
			default:             e = 6'sd0;
		endcase
		return e;
	endfunction

	// seven-sensor pattern table
	function automatic err_t map_seven(input logic [SENSOR_W-1:0] b);
		err_t e;
		unique case (b)
			8'hF7:   e = 6'sd0;
			8'hE7:   e = 6'sd1;
			8'hEF:   e = 6'sd2;
			8'hCF:   e = 6'sd3;
			8'hDF:   e = 6'sd4;
			8'h9F:   e = 6'sd5;
			8'hBF:   e = 6'sd6;
			8'hF3:   e = -6'sd1;
			8'hFB:   e = -6'sd2;
			8'hF9:   e = -6'sd3;
			8'hFD:   e = -6'sd4;
			8'hFC:   e = -6'sd5;
			8'hFE:   e = -6'sd6;
			default: e = 6'sd0;
		endcase
		return e;
	endfunction

endpackage

// ----- rtl/lssp_if.sv -----
// lssp_if: valid/ready channel interfaces for sensor input, results and configuration
// depends on lssp_pkg for widths
interface lssp_in_if;
	import lssp_pkg::*;
	logic                valid;
	logic                ready;
	logic [SENSOR_W-1:0] sensor_byte;
	modport source (output valid, output sensor_byte, input ready);
	modport sink   (input valid, input sensor_byte, output ready);
endinterface

interface lssp_out_if;
	import lssp_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [STEER_W-1:0]  steer_value;
	logic signed [ERR_W-1:0]    track_error;
	logic [SPEED_W-1:0]         target_speed;
	modport source (output valid, output steer_value, output track_error,
		output target_speed, input ready);
	modport sink   (input valid, input steer_value, input track_error,
		input target_speed, output ready);
endinterface

interface lssp_cfg_if;
	import lssp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/line_sensor_steering_pd_unit.sv -----
// line_sensor_steering_pd_unit: top level of the line sensor pd steering block
// depends on lssp_pkg and the channel interfaces in lssp_if
//
// One sensor byte per transaction gives one result transaction. The byte is
// mapped to a track error in the accept cycle; the pd steering value and the
// curve speed are then formed by bit-serial shift-and-add multipliers: the pd
// terms (with |error|*curve_coef alongside), then the square of that product,
// then the scaling of base_speed, and last the load of the output register.
// A new byte is accepted once the previous one is in the output register, even
// while that result still waits to be taken. Configuration writes are always
// accepted and must only be issued while the block is idle.
module line_sensor_steering_pd_unit (
	input  logic              clk,
	input  logic              arst_n,
	lssp_in_if.sink           sensor_ch,
	lssp_out_if.source        result_ch,
	lssp_cfg_if.sink          cfg_ch
);
	import lssp_pkg::*;

	localparam int PD_STEPS  = 7;
	localparam int SQ_STEPS  = 16;
	localparam int SPD_STEPS = 16;
	localparam int PD_W      = 7;
	localparam int ACC_W     = 24;
	localparam int PROD_W    = 21;
	localparam int SQ_W      = 32;
	localparam int FAC_W     = 33;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PD   = 2'd1;
	localparam logic [1:0] ST_SQ   = 2'd2;
	localparam logic [1:0] ST_SPD  = 2'd3;

	// configuration registers
	logic                      table_sel_q;
	logic signed [GAIN_W-1:0]  prop_gain_q;
	logic signed [GAIN_W-1:0]  deriv_gain_q;
	logic [SPEED_W-1:0]        base_speed_q;
	logic [GAIN_W-1:0]         curve_coef_q;

	// control
	logic [1:0]                state_q;
	logic [3:0]                cnt_q;
	logic                      done_q;
	logic                      out_valid_q;

	// datapath
	err_t                      prev_q;
	err_t                      err_q;
	logic [PD_W-1:0]           err_sr_q;
	logic [PD_W-1:0]           diff_sr_q;
	logic [PD_W-1:0]           mag_sr_q;
	logic signed [ACC_W-1:0]   steer_acc_q;
	logic [PROD_W-1:0]         prod_acc_q;
	logic [SPEED_W-1:0]        sq_mcand_q;
	logic [SPEED_W-1:0]        sq_sr_q;
	logic                      ovf_q;
	logic [SQ_W-1:0]           sq_acc_q;
	logic [FAC_W-1:0]          fac_q;
	logic [SPEED_W-1:0]        base_sr_q;
	logic [FAC_W-1:0]          spd_acc_q;

	logic signed [STEER_W-1:0] steer_out_q;
	err_t                      err_out_q;
	logic [SPEED_W-1:0]        speed_out_q;

	logic                      in_acc;
	logic                      zeros_ok;
	logic                      prev_pos;
	err_t                      err_new;
	logic [PD_W-1:0]           diff_new;
	logic [ERR_W-1:0]          mag_new;
	logic                      neg_step;
	logic signed [ACC_W-1:0]   pg_ext;
	logic signed [ACC_W-1:0]   dg_ext;
	logic signed [ACC_W-1:0]   term_e;
	logic signed [ACC_W-1:0]   term_d;
	logic signed [ACC_W-1:0]   steer_next;
	logic [PROD_W-1:0]         prod_next;
	logic [SQ_W-1:0]           sq_next;
	logic [FAC_W:0]            spd_sum;
	logic                      load_out;

	assign cfg_ch.ready    = 1'b1;
	assign sensor_ch.ready = (state_q == ST_IDLE) && !done_q;
	assign in_acc          = sensor_ch.valid && sensor_ch.ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_sel_q  <= TABLE_EIGHT;
			prop_gain_q  <= PROP_GAIN_RST;
			deriv_gain_q <= DERIV_GAIN_RST;
			base_speed_q <= BASE_SPEED_RST;
			curve_coef_q <= CURVE_COEF_RST;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_TABLE_SELECT: table_sel_q  <= cfg_ch.data[0];
				REG_PROP_GAIN:    prop_gain_q  <= cfg_ch.data;
				REG_DERIV_GAIN:   deriv_gain_q <= cfg_ch.data;
				REG_BASE_SPEED:   base_speed_q <= cfg_ch.data;
				REG_CURVE_COEF:   curve_coef_q <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	// error selection from the sensor byte
	always_comb begin
		zeros_ok = $countones(~sensor_ch.sensor_byte[6:0]) <= 2;
		prev_pos = !prev_q[ERR_W-1] && (prev_q != '0);
		if (!zeros_ok)
			err_new = prev_q;
		else if (table_sel_q == TABLE_SEVEN)
			err_new = map_seven(sensor_ch.sensor_byte);
		else
			err_new = map_eight(sensor_ch.sensor_byte, prev_pos);
		diff_new = {err_new[ERR_W-1], err_new} - {prev_q[ERR_W-1], prev_q};
		mag_new  = err_new[ERR_W-1] ? ERR_W'(-err_new) : ERR_W'(err_new);
	end

	// one step of each serial multiplier
	always_comb begin
		neg_step   = (cnt_q == 4'(PD_STEPS - 1));
		pg_ext     = ACC_W'(prop_gain_q);
		dg_ext     = ACC_W'(deriv_gain_q);
		term_e     = err_sr_q[PD_W-1] ? (neg_step ? -pg_ext : pg_ext) : '0;
		term_d     = diff_sr_q[PD_W-1] ? (neg_step ? -dg_ext : dg_ext) : '0;
		steer_next = (steer_acc_q <<< 1) + term_e + term_d;
		prod_next  = (prod_acc_q << 1)
			+ (mag_sr_q[PD_W-1] ? PROD_W'(curve_coef_q) : PROD_W'(0));
		sq_next    = (sq_acc_q << 1) + (sq_sr_q[SPEED_W-1] ? SQ_W'(sq_mcand_q) : SQ_W'(0));
		spd_sum    = {1'b0, spd_acc_q} + (base_sr_q[0] ? {1'b0, fac_q} : '0);
		load_out   = done_q && (!out_valid_q || result_ch.ready);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			prev_q  <= '0;
		end else begin
			if (load_out)
				done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						prev_q  <= err_new;
						cnt_q   <= 4'(PD_STEPS - 1);
						state_q <= ST_PD;
					end
				end
				ST_PD: begin
					if (cnt_q == '0) begin
						cnt_q   <= 4'(SQ_STEPS - 1);
						state_q <= ST_SQ;
					end else begin
						cnt_q <= cnt_q - 4'd1;
					end
				end
				ST_SQ: begin
					if (cnt_q == '0) begin
						cnt_q   <= 4'(SPD_STEPS - 1);
						state_q <= ST_SPD;
					end else begin
						cnt_q <= cnt_q - 4'd1;
					end
				end
				ST_SPD: begin
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q - 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// serial datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					err_q       <= err_new;
					err_sr_q    <= {err_new[ERR_W-1], err_new};
					diff_sr_q   <= diff_new;
					mag_sr_q    <= {1'b0, mag_new};
					steer_acc_q <= '0;
					prod_acc_q  <= '0;
				end
			end
			ST_PD: begin
				steer_acc_q <= steer_next;
				prod_acc_q  <= prod_next;
				err_sr_q    <= err_sr_q << 1;
				diff_sr_q   <= diff_sr_q << 1;
				mag_sr_q    <= mag_sr_q << 1;
				if (cnt_q == '0) begin
					sq_mcand_q <= prod_next[SPEED_W-1:0];
					sq_sr_q    <= prod_next[SPEED_W-1:0];
					ovf_q      <= |prod_next[PROD_W-1:SPEED_W];
					sq_acc_q   <= '0;
				end
			end
			ST_SQ: begin
				sq_acc_q <= sq_next;
				sq_sr_q  <= sq_sr_q << 1;
				if (cnt_q == '0) begin
					fac_q     <= ovf_q ? '0 : ({1'b1, {SQ_W{1'b0}}} - {1'b0, sq_next});
					base_sr_q <= base_speed_q;
					spd_acc_q <= '0;
				end
			end
			ST_SPD: begin
				spd_acc_q <= spd_sum[FAC_W:1];
				base_sr_q <= base_sr_q >> 1;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (result_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			steer_out_q <= steer_acc_q[STEER_W-1:0];
			err_out_q   <= err_q;
			speed_out_q <= spd_acc_q[SQ_W-1:SPEED_W];
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.steer_value  = steer_out_q;
	assign result_ch.track_error  = err_out_q;
	assign result_ch.target_speed = speed_out_q;

endmodule

// ----- rtl/lssp_checker.sv -----
// lssp_checker: port-level assertions for line_sensor_steering_pd_unit, with its bind
// depends on lssp_pkg for widths
module lssp_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [lssp_pkg::STEER_W-1:0]  steer_value,
	input logic signed [lssp_pkg::ERR_W-1:0]    track_error,
	input logic [lssp_pkg::SPEED_W-1:0]         target_speed
);
	import lssp_pkg::*;

	// track error stays within the table range
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (track_error >= ERR_FULL_NEG) && (track_error <= ERR_FULL_POS))
		else $error("track_error out of range");

	// an accepted byte closes the input behind it
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted during a running item");

	// a pending result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result withdrawn before transaction");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		($stable(steer_value) && $stable(track_error) && $stable(target_speed)))
		else $error("result payload changed while stalled");

endmodule

bind line_sensor_steering_pd_unit lssp_checker u_lssp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sensor_ch.valid),
	.in_ready     (sensor_ch.ready),
	.out_valid    (result_ch.valid),
	.out_ready    (result_ch.ready),
	.steer_value  (result_ch.steer_value),
	.track_error  (result_ch.track_error),
	.target_speed (result_ch.target_speed)
);
